### sv/hsc_pkg.sv
package hsc_pkg;

    localparam int MAX_DATA_BITS = 57;
    localparam int CODE_W        = 63;
    localparam int DATA_W        = 57;
    localparam int SYN_W         = 6;
    localparam int K_W           = 6;

    localparam logic [K_W-1:0] K_RESET = K_W'(4);
    localparam logic [K_W-1:0] K_MIN   = K_W'(1);
    localparam logic [K_W-1:0] K_MAX   = K_W'(MAX_DATA_BITS);

    localparam logic ACTION_ENCODE = 1'b0;
    localparam logic ACTION_DECODE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_CORRECTED = 2'd1,
        STATUS_BEYOND    = 2'd2
    } status_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_word;
        logic [DATA_W-1:0] data_out;
        logic [SYN_W-1:0]  syndrome;
        status_t           status;
    } hsc_result_t;

    // Positions (1-based) whose index has bit b set; the parity at 2^b covers them.
    function automatic logic [CODE_W-1:0] cover_mask(input int b);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int p = 1; p <= CODE_W; p++) begin
            m[p-1] = ((p >> b) & 1) != 0;
        end
        return m;
    endfunction

    // Code length n = k + r for an effective message length k in 1..57.
    function automatic logic [K_W-1:0] code_len(input logic [K_W-1:0] k);
        logic [K_W-1:0] r;
        if (k <= K_W'(1)) begin
            r = K_W'(2);
        end else if (k <= K_W'(4)) begin
            r = K_W'(3);
        end else if (k <= K_W'(11)) begin
            r = K_W'(4);
        end else if (k <= K_W'(26)) begin
            r = K_W'(5);
        end else begin
            r = K_W'(6);
        end
        return k + r;
    endfunction

    // XOR of the positions of all set bits, one parity tree per syndrome bit.
    function automatic logic [SYN_W-1:0] syndrome_of(input logic [CODE_W-1:0] cw);
        logic [SYN_W-1:0] s;
        for (int b = 0; b < SYN_W; b++) begin
            s[b] = ^(cw & cover_mask(b));
        end
        return s;
    endfunction

    // Message bits go to the positions that are not powers of two, in order.
    function automatic logic [CODE_W-1:0] scatter(input logic [DATA_W-1:0] d);
        logic [CODE_W-1:0] cw;
        int i;
        cw = '0;
        i  = 0;
        for (int p = 1; p <= CODE_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                cw[p-1] = d[i];
                i++;
            end
        end
        return cw;
    endfunction

    function automatic logic [DATA_W-1:0] gather(input logic [CODE_W-1:0] cw);
        logic [DATA_W-1:0] d;
        int i;
        d = '0;
        i = 0;
        for (int p = 1; p <= CODE_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                d[i] = cw[p-1];
                i++;
            end
        end
        return d;
    endfunction

endpackage

### sv/hamming_sec_codec.sv
// Hamming single-error-correcting encoder and decoder for a message length of
// 1 to 57 bits, set through cfg_wr_en/cfg_wr_data (0 acts as 1, above 57 as 57).
// Each transfer is either an encode of the message in the low bits of s_tdata or
// a decode of a received codeword, selected by s_tuser. An item passes through
// an input register and then a result register, with the parity trees and
// position selection between them; the block sustains one item per cycle while
// m_tready is high, and the syndrome XOR trees in that single stage set the
// clock rate. While the result waits on m_tready the input register still takes
// one transfer, and then s_tready drops.
module hamming_sec_codec import hsc_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [K_W-1:0] cfg_wr_data,  // data_bits
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [63:0]    s_tdata,      // word_in[62:0], zero pad
    input  logic [0:0]     s_tuser,      // action
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [127:0]   m_tdata,      // code_word[62:0], data_out[119:63],
                                         // syndrome[125:120], zero pad
    output logic [1:0]     m_tuser       // status
);

    logic [K_W-1:0]    data_bits_reg;
    logic              in_valid_reg;
    logic              in_action_reg;
    logic [CODE_W-1:0] in_word_reg;
    logic              out_valid_reg;
    hsc_result_t       out_result_reg;
    hsc_result_t       result_next;
    logic              advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_bits_reg <= K_RESET;
        end else if (cfg_wr_en) begin
            data_bits_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser[0];
            in_word_reg   <= s_tdata[CODE_W-1:0];
        end
        if (advance && in_valid_reg) begin
            out_result_reg <= result_next;
        end
    end

    hsc_core u_core (
        .action    (in_action_reg),
        .word_in   (in_word_reg),
        .data_bits (data_bits_reg),
        .result    (result_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_result_reg.syndrome, out_result_reg.data_out,
                       out_result_reg.code_word};
    assign m_tuser  = out_result_reg.status;

endmodule

### sv/hsc_core.sv
module hsc_core import hsc_pkg::*; (
    input  logic              action,
    input  logic [CODE_W-1:0] word_in,
    input  logic [K_W-1:0]    data_bits,
    output hsc_result_t       result
);

    logic [K_W-1:0]    k_eff;
    logic [K_W-1:0]    n_len;
    logic [DATA_W-1:0] data_masked;
    logic [CODE_W-1:0] cw_masked;
    logic [CODE_W-1:0] data_cw;
    logic [CODE_W-1:0] enc_cw;
    logic [SYN_W-1:0]  enc_syn;
    logic [SYN_W-1:0]  dec_syn;
    logic [CODE_W-1:0] flip;
    logic [CODE_W-1:0] dec_cw;
    status_t           dec_status;

    always_comb begin
        if (data_bits < K_MIN) begin
            k_eff = K_MIN;
        end else if (data_bits > K_MAX) begin
            k_eff = K_MAX;
        end else begin
            k_eff = data_bits;
        end
        n_len = code_len(k_eff);
    end

    always_comb begin
        for (int i = 0; i < DATA_W; i++) begin
            data_masked[i] = word_in[i] & (i < int'(k_eff));
        end
        for (int j = 0; j < CODE_W; j++) begin
            cw_masked[j] = word_in[j] & (j < int'(n_len));
        end
    end

    // Encode: the syndrome of the bare message bits is exactly the parity pattern.
    always_comb begin
        data_cw = scatter(data_masked);
        enc_syn = syndrome_of(data_cw);
        enc_cw  = data_cw;
        for (int b = 0; b < SYN_W; b++) begin
            if (enc_syn[b]) begin
                enc_cw[(1 << b) - 1] = 1'b1;
            end
        end
    end

    always_comb begin
        dec_syn = syndrome_of(cw_masked);
        for (int j = 0; j < CODE_W; j++) begin
            flip[j] = (dec_syn == SYN_W'(j + 1)) && (dec_syn <= n_len);
        end
        dec_cw = cw_masked ^ flip;
        if (dec_syn == '0) begin
            dec_status = STATUS_OK;
        end else if (dec_syn <= n_len) begin
            dec_status = STATUS_CORRECTED;
        end else begin
            dec_status = STATUS_BEYOND;
        end
    end

    always_comb begin
        if (action == ACTION_DECODE) begin
            result.code_word = dec_cw;
            result.data_out  = gather(dec_cw);
            result.syndrome  = dec_syn;
            result.status    = dec_status;
        end else begin
            result.code_word = enc_cw;
            result.data_out  = data_masked;
            result.syndrome  = '0;
            result.status    = STATUS_OK;
        end
    end

endmodule

### sv/hsc_checker.sv
module hsc_checker import hsc_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // A stalled result keeps its valid.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined status code");

    // No error reported means a zero syndrome, and a correction or a beyond report needs a nonzero one.
    a_ok_syn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_OK |-> m_tdata[125:120] == '0)
        else $error("clean status with nonzero syndrome");

    a_fix_syn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_CORRECTED || m_tuser == STATUS_BEYOND)
            |-> m_tdata[125:120] != '0)
        else $error("error status with zero syndrome");

endmodule

bind hamming_sec_codec hsc_checker u_hsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
